### rtl/md5_sha1_sha256_hash_engine_core_macros.svh
// Assertion macros for the hash engine checker.
// Used by the checker file only.
`ifndef MD5_SHA1_SHA256_HASH_ENGINE_CORE_MACROS_SVH
`define MD5_SHA1_SHA256_HASH_ENGINE_CORE_MACROS_SVH
`define HE_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define HE_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### rtl/mshe_pkg.sv
// Shared types, constants and round tables for the hash engine.
// No dependencies.
package mshe_pkg;
  localparam logic [1:0] HT_MD5 = 2'd0;
  localparam logic [1:0] HT_SHA1 = 2'd1;
  localparam logic [1:0] HT_SHA256 = 2'd2;
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       start;
    logic [1:0] hash_type;
  } comp_ctl_t;

  function automatic logic [31:0] iv_word(input logic [1:0] ht, input logic [2:0] i);
    logic [31:0] v;
    v = 32'd0;
    if (ht == HT_MD5 || ht == HT_SHA1) begin
      case (i)
        3'd0: v = 32'h67452301;
        3'd1: v = 32'hefcdab89;
        3'd2: v = 32'h98badcfe;
        3'd3: v = 32'h10325476;
        3'd4: v = (ht == HT_SHA1) ? 32'hc3d2e1f0 : 32'd0;
        default: v = 32'd0;
      endcase
    end else begin
      case (i)
        3'd0: v = 32'h6a09e667;
        3'd1: v = 32'hbb67ae85;
        3'd2: v = 32'h3c6ef372;
        3'd3: v = 32'ha54ff53a;
        3'd4: v = 32'h510e527f;
        3'd5: v = 32'h9b05688c;
        3'd6: v = 32'h1f83d9ab;
        default: v = 32'h5be0cd19;
      endcase
    end
    return v;
  endfunction

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf,
    32'h4787c62a, 32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af,
    32'hffff5bb1, 32'h895cd7be, 32'h6b901122, 32'hfd987193, 32'ha679438e,
    32'h49b40821, 32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8, 32'h21e1cde6,
    32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122,
    32'hfde5380c, 32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05, 32'hd9d4d039,
    32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665, 32'hf4292244, 32'h432aff97,
    32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d,
    32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

  localparam logic [4:0] MD5_ROT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};

  localparam logic [31:0] SHA2_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rol32(input logic [31:0] v, input logic [4:0] n);
    return (v << n) | (v >> (6'd32 - {1'b0, n}));
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
    return (v >> n) | (v << (6'd32 - {1'b0, n}));
  endfunction
endpackage

### rtl/mshe_stream_if.sv
// Valid/ready stream interface used by the hash engine's channels.
// Depends on mshe_pkg for payload types.
interface mshe_in_if;
  logic                 valid;
  logic                 ready;
  mshe_pkg::in_item_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mshe_out_if;
  logic                 valid;
  logic                 ready;
  mshe_pkg::out_word_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/mshe_compress.sv
// Iterative compression unit: one MD5, SHA-1 or SHA-256 round per cycle.
// Depends on mshe_pkg. Reads message words from the block buffer by index.
module mshe_compress (
  input  logic                clk,
  input  logic                rst,
  input  mshe_pkg::comp_ctl_t ctl,
  input  logic [31:0]         chain_in [8],
  input  logic [31:0]         msg_word,
  output logic [3:0]          msg_addr,
  output logic                busy,
  output logic                done,
  output logic [31:0]         result [8]
);
  import mshe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_ROUND = 4'b0100,
    S_ADD = 4'b1000
  } cstate_t;

  cstate_t state;
  logic [1:0] ht;
  logic [6:0] rnd;
  logic [31:0] r [8];
  logic [31:0] w [16];
  logic [31:0] msg_le;
  logic [6:0] last_rnd;
  logic [31:0] f, kk, t1, t2, wnew, wcur, s0, s1;
  logic [3:0] g;
  logic [5:0] r6;

  assign busy = (state != S_IDLE);
  assign msg_le = {msg_word[7:0], msg_word[15:8], msg_word[23:16], msg_word[31:24]};
  assign last_rnd = (ht == HT_SHA1) ? 7'd79 : 7'd63;
  assign r6 = rnd[5:0];
  // During load, rnd counts the sixteen message words.
  assign msg_addr = (state == S_LOAD) ? rnd[3:0] : 4'd0;

  always_comb begin
    logic [31:0] a15, a2;
    a15 = w[4'(rnd[3:0] + 4'd1)];
    a2 = w[4'(rnd[3:0] + 4'd14)];
    g = rnd[3:0];
    f = 32'd0;
    kk = 32'd0;
    wnew = w[rnd[3:0]];
    s0 = 32'd0;
    s1 = 32'd0;
    t1 = 32'd0;
    t2 = 32'd0;
    if (ht == HT_MD5) begin
      case (r6[5:4])
        2'd0: begin
          f = (r[1] & r[2]) | (~r[1] & r[3]);
          g = r6[3:0];
        end
        2'd1: begin
          f = (r[3] & r[1]) | (~r[3] & r[2]);
          g = 4'(r6 * 6'd5 + 6'd1);
        end
        2'd2: begin
          f = r[1] ^ r[2] ^ r[3];
          g = 4'(r6 * 6'd3 + 6'd5);
        end
        default: begin
          f = r[2] ^ (r[1] | ~r[3]);
          g = 4'(r6 * 6'd7);
        end
      endcase
      t1 = f + r[0] + MD5_K[r6] + w[g];
      wcur = w[g];
    end else if (ht == HT_SHA1) begin
      if (rnd >= 7'd16)
        wnew = rol32(w[4'(rnd[3:0] + 4'd13)] ^ w[4'(rnd[3:0] + 4'd8)] ^
                     w[4'(rnd[3:0] + 4'd2)] ^ w[rnd[3:0]], 5'd1);
      if (rnd < 7'd20) begin
        f = (r[1] & r[2]) | (~r[1] & r[3]); kk = 32'h5a827999;
      end else if (rnd < 7'd40) begin
        f = r[1] ^ r[2] ^ r[3]; kk = 32'h6ed9eba1;
      end else if (rnd < 7'd60) begin
        f = (r[1] & r[2]) | (r[1] & r[3]) | (r[2] & r[3]); kk = 32'h8f1bbcdc;
      end else begin
        f = r[1] ^ r[2] ^ r[3]; kk = 32'hca62c1d6;
      end
      wcur = wnew;
      t1 = rol32(r[0], 5'd5) + f + r[4] + kk + wnew;
    end else begin
      if (rnd >= 7'd16)
        wnew = w[rnd[3:0]] +
               (ror32(a15, 5'd7) ^ ror32(a15, 5'd18) ^ (a15 >> 3)) +
               w[4'(rnd[3:0] + 4'd9)] +
               (ror32(a2, 5'd17) ^ ror32(a2, 5'd19) ^ (a2 >> 10));
      wcur = wnew;
      s1 = ror32(r[4], 5'd6) ^ ror32(r[4], 5'd11) ^ ror32(r[4], 5'd25);
      f = (r[4] & r[5]) ^ (~r[4] & r[6]);
      t1 = r[7] + s1 + f + SHA2_K[r6] + wnew;
      s0 = ror32(r[0], 5'd2) ^ ror32(r[0], 5'd13) ^ ror32(r[0], 5'd22);
      t2 = s0 + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (ctl.start) begin
            ht <= ctl.hash_type;
            rnd <= 7'd0;
            state <= S_LOAD;
            for (int i = 0; i < 8; i++) r[i] <= chain_in[i];
          end
        end
        S_LOAD: begin
          w[rnd[3:0]] <= (ht == HT_MD5) ? msg_le : msg_word;
          if (rnd == 7'd15) begin
            rnd <= 7'd0;
            state <= S_ROUND;
          end else begin
            rnd <= rnd + 7'd1;
          end
        end
        S_ROUND: begin
          if (ht == HT_MD5) begin
            r[0] <= r[3]; r[3] <= r[2]; r[2] <= r[1];
            r[1] <= r[1] + rol32(t1, MD5_ROT[{r6[5:4], r6[1:0]}]);
          end else if (ht == HT_SHA1) begin
            w[rnd[3:0]] <= wnew;
            r[4] <= r[3]; r[3] <= r[2]; r[2] <= rol32(r[1], 5'd30);
            r[1] <= r[0]; r[0] <= t1;
          end else begin
            w[rnd[3:0]] <= wnew;
            r[7] <= r[6]; r[6] <= r[5]; r[5] <= r[4]; r[4] <= r[3] + t1;
            r[3] <= r[2]; r[2] <= r[1]; r[1] <= r[0]; r[0] <= t1 + t2;
          end
          if (rnd == last_rnd) state <= S_ADD;
          rnd <= rnd + 7'd1;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) result[i] <= chain_in[i] + r[i];
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic unused_wcur;
  assign unused_wcur = ^wcur;
endmodule

### rtl/md5_sha1_sha256_hash_engine_core.sv
// MD5 / SHA-1 / SHA-256 digest engine. An absorb that fills a 64-byte block runs a compression
// and takes no new byte until it is done: start, the load of the sixteen message words, the rounds
// in the shared round unit, the final add and the hand-back. A finish pads one byte per cycle up
// to the length field (to the block end, a compression, then zeros in bytes 0 to 55 when it does
// not fit), writes the length field, compresses the last block, then emits one digest word
// per cycle while the output is ready. Reset (rst, synchronous) selects SHA-256, empty message.
module md5_sha1_sha256_hash_engine_core (
  input  logic              clk,
  input  logic              rst,
  mshe_in_if.sink           in_ch,
  mshe_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import mshe_pkg::*;

  typedef enum logic [6:0] {
    T_IDLE = 7'b0000001,
    T_COMP = 7'b0000010,
    T_PAD = 7'b0000100,
    T_PCOMP = 7'b0001000,
    T_LEN = 7'b0010000,
    T_LCOMP = 7'b0100000,
    T_EMIT = 7'b1000000
  } tstate_t;

  tstate_t state;
  logic [1:0] hash_type;
  logic [31:0] chain [8];
  logic [31:0] buffer [16];
  logic [6:0] fill_count;
  logic [63:0] message_length;
  logic [63:0] bits;
  logic [5:0] pad_ptr;
  logic [2:0] emit_idx;
  logic [2:0] last_idx;
  logic [31:0] msg_word;
  logic [3:0] msg_addr;
  logic comp_busy, comp_done;
  logic [31:0] comp_result [8];
  comp_ctl_t ctl;
  logic cfg_we;
  logic [7:0] len_byte;
  logic [2:0] len_pos;
  logic wr_en;
  logic [5:0] wr_addr;
  logic [7:0] wr_byte;

  assign pready = 1'b1;
  assign prdata = {30'd0, hash_type};
  assign cfg_we = psel && penable && pwrite && (paddr == 2'd0);
  assign in_ch.ready = (state == T_IDLE) && !out_ch.valid;
  assign last_idx = (hash_type == HT_MD5) ? 3'd3 : ((hash_type == HT_SHA1) ? 3'd4 : 3'd7);
  // Each buffer entry holds four block bytes, the first one in bits 31:24.
  assign msg_word = buffer[msg_addr];
  // Length byte for buffer slot 56+len_pos: MD5 little-endian, others big-endian.
  assign len_pos = pad_ptr[2:0];
  assign len_byte = (hash_type == HT_MD5) ? bits[8*len_pos +: 8] : bits[8*(3'd7 - len_pos) +: 8];

  mshe_compress u_comp (
    .clk(clk), .rst(rst), .ctl(ctl), .chain_in(chain), .msg_word(msg_word),
    .msg_addr(msg_addr), .busy(comp_busy), .done(comp_done), .result(comp_result)
  );

  always_comb begin
    wr_en = 1'b0;
    wr_addr = fill_count[5:0];
    wr_byte = in_ch.payload.data_byte;
    if (in_ch.valid && in_ch.ready && in_ch.payload.op == OP_ABSORB) begin
      wr_en = 1'b1;
    end else if (state == T_PAD) begin
      wr_en = 1'b1;
      wr_addr = pad_ptr;
      // The 0x80 marker goes only into the first padded block, right after the last message byte.
      wr_byte = (pad_ptr == fill_count[5:0] && !fill_count[6]) ? 8'h80 : 8'h00;
    end else if (state == T_LEN) begin
      wr_en = 1'b1;
      wr_addr = {3'b111, len_pos};
      wr_byte = len_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en)
      buffer[wr_addr[5:2]][8*(2'd3 - wr_addr[1:0]) +: 8] <= wr_byte;
  end

  always_ff @(posedge clk) begin
    ctl.start <= 1'b0;
    ctl.hash_type <= hash_type;
    if (rst) begin
      state <= T_IDLE;
      hash_type <= HT_SHA256;
      fill_count <= 7'd0;
      message_length <= 64'd0;
      out_ch.valid <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= iv_word(HT_SHA256, 3'(i));
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (cfg_we) begin
        hash_type <= pwdata[1:0];
        fill_count <= 7'd0;
        message_length <= 64'd0;
        for (int i = 0; i < 8; i++) chain[i] <= iv_word(pwdata[1:0], 3'(i));
      end
      case (state)
        T_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            if (in_ch.payload.op == OP_ABSORB) begin
              message_length <= message_length + 64'd1;
              if (fill_count == 7'd63) begin
                fill_count <= 7'd0;
                ctl.start <= 1'b1;
                state <= T_COMP;
              end else begin
                fill_count <= fill_count + 7'd1;
              end
            end else begin
              bits <= {message_length[60:0], 3'd0};
              pad_ptr <= fill_count[5:0];
              state <= T_PAD;
            end
          end
        end
        T_COMP: begin
          if (comp_done) begin
            for (int i = 0; i < 8; i++) chain[i] <= comp_result[i];
            state <= T_IDLE;
          end
        end
        T_PAD: begin
          // Zero fill up to the length field, or to block end if it does not fit.
          if (pad_ptr == 6'd55 && (fill_count < 7'd56 || fill_count[6])) begin
            pad_ptr <= 6'd0;
            state <= T_LEN;
          end else if (pad_ptr == 6'd63) begin
            ctl.start <= 1'b1;
            fill_count <= 7'd64;
            state <= T_PCOMP;
          end else begin
            pad_ptr <= pad_ptr + 6'd1;
          end
        end
        T_PCOMP: begin
          if (comp_done) begin
            for (int i = 0; i < 8; i++) chain[i] <= comp_result[i];
            pad_ptr <= 6'd0;
            state <= T_PAD;
          end
        end
        T_LEN: begin
          if (len_pos == 3'd7) begin
            ctl.start <= 1'b1;
            state <= T_LCOMP;
          end
          pad_ptr <= pad_ptr + 6'd1;
        end
        T_LCOMP: begin
          if (comp_done) begin
            for (int i = 0; i < 8; i++) chain[i] <= comp_result[i];
            emit_idx <= 3'd0;
            state <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            out_ch.payload.digest_word <= (hash_type == HT_MD5) ?
              {chain[emit_idx][7:0], chain[emit_idx][15:8],
               chain[emit_idx][23:16], chain[emit_idx][31:24]} : chain[emit_idx];
            out_ch.payload.word_index <= emit_idx;
            out_ch.payload.last_word <= (emit_idx == last_idx);
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == last_idx) begin
              fill_count <= 7'd0;
              message_length <= 64'd0;
              for (int i = 0; i < 8; i++) chain[i] <= iv_word(hash_type, 3'(i));
              state <= T_IDLE;
            end
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  logic unused_busy;
  assign unused_busy = comp_busy ^ (^pwdata[31:2]);
endmodule

### rtl/mshe_checker.sv
// Port-level checker for the hash engine, bound to the top level.
// Depends on mshe_pkg and the assertion macro header.
`include "md5_sha1_sha256_hash_engine_core_macros.svh"
module mshe_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input mshe_pkg::out_word_t out_payload
);
  import mshe_pkg::*;
  `HE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_payload))
  `HE_ASSERT_IMPL(a_busy_out, clk, rst, out_valid, !in_ready)
  `HE_ASSERT_NEXT(a_idx_step, clk, rst, out_valid && out_ready && !out_payload.last_word, out_valid && out_payload.word_index == $past(out_payload.word_index) + 3'd1)
  `HE_ASSERT_IMPL(a_first_idx, clk, rst, out_valid && !$past(out_valid) && !$past(rst), out_payload.word_index == 3'd0)
endmodule

bind md5_sha1_sha256_hash_engine_core mshe_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);

### test/md5_sha1_sha256_hash_engine_core_tb.sv
// Self-checking testbench for the MD5 / SHA-1 / SHA-256 digest engine core.
// Depends on mshe_pkg and the stream interfaces; predicts digests in-bench.
`timescale 1ns / 100ps

module md5_sha1_sha256_hash_engine_core_tb;
  import mshe_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [1:0] HT_RSVD = 2'd3;
  localparam logic [1:0] REG_HASH_TYPE = 2'd0;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  mshe_in_if in_ch();
  mshe_out_if out_ch();

  md5_sha1_sha256_hash_engine_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Predictor state.
  logic [1:0]  alg_sel;
  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  int          fill;
  logic [63:0] msg_len;

  out_word_t digest_q[$];
  int errors;
  int cycles;
  bit hold_long;
  int hold_count;

  localparam logic [31:0] IV_SHA2 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    n = n % 32;
    if (n == 0) return v;
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] rotr(logic [31:0] v, int n);
    return rotl(v, (32 - n) % 32);
  endfunction

  task automatic restart_message();
    for (int i = 0; i < 8; i++) begin
      if (alg_sel == HT_MD5) chain[i] = (i < 4) ? IV_SHA2[0] : 32'd0;
      else chain[i] = 32'd0;
    end
    if (alg_sel == HT_MD5 || alg_sel == HT_SHA1) begin
      chain[0] = 32'h67452301; chain[1] = 32'hefcdab89;
      chain[2] = 32'h98badcfe; chain[3] = 32'h10325476;
      chain[4] = (alg_sel == HT_SHA1) ? 32'hc3d2e1f0 : 32'd0;
    end else begin
      for (int i = 0; i < 8; i++) chain[i] = IV_SHA2[i];
    end
    fill = 0;
    msg_len = 64'd0;
  endtask

  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] r [8];
    logic [31:0] f, k, t, t1, t2, a15, a2;
    int g;
    for (int i = 0; i < 16; i++) begin
      if (alg_sel == HT_MD5)
        w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
      else
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    end
    for (int i = 0; i < 8; i++) r[i] = chain[i];
    if (alg_sel == HT_MD5) begin
      for (int i = 0; i < 64; i++) begin
        if (i < 16) begin f = (r[1] & r[2]) | (~r[1] & r[3]); g = i; end
        else if (i < 32) begin f = (r[3] & r[1]) | (~r[3] & r[2]); g = (5*i+1) % 16; end
        else if (i < 48) begin f = r[1] ^ r[2] ^ r[3]; g = (3*i+5) % 16; end
        else begin f = r[2] ^ (r[1] | ~r[3]); g = (7*i) % 16; end
        f = f + r[0] + MD5_K[i] + w[g];
        r[0] = r[3]; r[3] = r[2]; r[2] = r[1];
        r[1] = r[1] + rotl(f, MD5_ROT[((i/16)*4) + (i%4)]);
      end
      for (int i = 0; i < 4; i++) chain[i] += r[i];
    end else if (alg_sel == HT_SHA1) begin
      for (int i = 0; i < 80; i++) begin
        if (i >= 16)
          w[i%16] = rotl(w[(i-3)%16] ^ w[(i-8)%16] ^ w[(i-14)%16] ^ w[i%16], 1);
        if (i < 20) begin f = (r[1] & r[2]) | (~r[1] & r[3]); k = 32'h5a827999; end
        else if (i < 40) begin f = r[1] ^ r[2] ^ r[3]; k = 32'h6ed9eba1; end
        else if (i < 60) begin
          f = (r[1] & r[2]) | (r[1] & r[3]) | (r[2] & r[3]); k = 32'h8f1bbcdc;
        end else begin f = r[1] ^ r[2] ^ r[3]; k = 32'hca62c1d6; end
        t = rotl(r[0], 5) + f + r[4] + k + w[i%16];
        r[4] = r[3]; r[3] = r[2]; r[2] = rotl(r[1], 30); r[1] = r[0]; r[0] = t;
      end
      for (int i = 0; i < 5; i++) chain[i] += r[i];
    end else begin
      for (int i = 0; i < 64; i++) begin
        if (i >= 16) begin
          a15 = w[(i-15)%16]; a2 = w[(i-2)%16];
          w[i%16] = w[i%16] + (rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3)) +
                    w[(i-7)%16] + (rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10));
        end
        t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25)) +
             ((r[4] & r[5]) ^ (~r[4] & r[6])) + SHA2_K[i] + w[i%16];
        t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22)) +
             ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
        r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
        r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += r[i];
    end
  endtask

  task automatic predict_item(in_item_t it);
    logic [63:0] bits;
    int nwords;
    out_word_t ow;
    if (it.op == OP_ABSORB) begin
      blk[fill] = it.data_byte;
      msg_len += 64'd1;
      fill++;
      if (fill >= 64) begin
        compress_block();
        fill = 0;
      end
      return;
    end
    bits = msg_len << 3;
    blk[fill] = 8'h80;
    fill++;
    if (fill > 56) begin
      for (int i = fill; i < 64; i++) blk[i] = 8'h00;
      compress_block();
      fill = 0;
    end
    for (int i = fill; i < 56; i++) blk[i] = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (alg_sel == HT_MD5) blk[56+i] = bits[8*i +: 8];
      else blk[63-i] = bits[8*i +: 8];
    end
    compress_block();
    nwords = (alg_sel == HT_MD5) ? 4 : ((alg_sel == HT_SHA1) ? 5 : 8);
    for (int i = 0; i < nwords; i++) begin
      ow.digest_word = (alg_sel == HT_MD5) ?
        {chain[i][7:0], chain[i][15:8], chain[i][23:16], chain[i][31:24]} : chain[i];
      ow.word_index = i[2:0];
      ow.last_word = (i == nwords - 1);
      digest_q.push_back(ow);
    end
    restart_message();
  endtask

  // Short gaps mostly, an occasional long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Valid stays high after an accept so that a word with no gap follows at once.
  task automatic send_item(logic op, logic [7:0] data);
    in_item_t it;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.op = op;
    it.data_byte = data;
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(it);
  endtask

  task automatic send_message(int nbytes);
    for (int i = 0; i < nbytes; i++) send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
    send_item(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // Waits out the queue plus the engine's worst compression time.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_hash_type(logic [1:0] ht);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= REG_HASH_TYPE; pwdata <= {30'd0, ht};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    alg_sel = ht;
    restart_message();
    @(posedge clk);
  endtask

  task automatic test_reset_default();
    send_message(0);
    send_message(3);
    drain();
  endtask

  task automatic test_boundaries(logic [1:0] ht, int len_a, int len_b);
    write_hash_type(ht);
    send_message(0);
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_ABSORB, 8'hff);
    send_item(OP_ABSORB, 8'haa);
    send_item(OP_ABSORB, 8'h55);
    send_item(OP_FINISH, 8'hff);
    send_message(len_a);
    send_message(len_b);
    drain();
  endtask

  task automatic test_restart_on_write();
    write_hash_type(HT_SHA1);
    for (int i = 0; i < 20; i++) send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
    drain();
    write_hash_type(HT_MD5);
    send_message(5);
    drain();
  endtask

  task automatic test_backpressure();
    write_hash_type(HT_SHA256);
    hold_long = 1'b1;
    send_message(2);
    send_message(1);
    send_message(0);
    hold_long = 1'b0;
    drain();
  endtask

  task automatic test_random(int items);
    int sent;
    int len;
    logic [1:0] ht_list [4];
    ht_list = '{HT_MD5, HT_SHA1, HT_SHA256, HT_RSVD};
    sent = 0;
    while (sent < items) begin
      write_hash_type(ht_list[$urandom_range(0, 3)]);
      for (int m = 0; m < 6 && sent < items; m++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 140) : $urandom_range(0, 20);
        send_message(len);
        sent += len + 1;
      end
      drain();
    end
  endtask

  // Ready on the result side: random stalls, plus one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_count <= 0;
    end else if (hold_long && hold_count < 400) begin
      out_ch.ready <= 1'b0;
      hold_count <= hold_count + 1;
    end else if (!hold_long && hold_count >= 400) begin
      hold_count <= 0;
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 9) < 7);
    end
  end

  always @(posedge clk) begin
    out_word_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word %h idx %0d last %0b", $time,
                 got.digest_word, got.word_index, got.last_word);
        errors++;
      end else begin
        want = digest_q.pop_front();
        if (got.digest_word !== want.digest_word) begin
          $display("%0t: digest_word expected %h actual %h", $time,
                   want.digest_word, got.digest_word);
          errors++;
        end
        if (got.word_index !== want.word_index) begin
          $display("%0t: word_index expected %0d actual %0d", $time,
                   want.word_index, got.word_index);
          errors++;
        end
        if (got.last_word !== want.last_word) begin
          $display("%0t: last_word expected %0b actual %0b", $time,
                   want.last_word, got.last_word);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("md5_sha1_sha256_hash_engine_core verification failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    hold_long = 1'b0;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    alg_sel = HT_SHA256;
    restart_message();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_default();
    test_boundaries(HT_MD5, 55, 56);
    test_boundaries(HT_SHA1, 63, 64);
    test_boundaries(HT_SHA256, 55, 64);
    test_boundaries(HT_RSVD, 56, 63);
    test_restart_on_write();
    test_backpressure();
    test_random(40);

    if (digest_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("md5_sha1_sha256_hash_engine_core verification clean");
    end else begin
      $display("md5_sha1_sha256_hash_engine_core verification failed");
    end
    $finish;
  end
endmodule
